>>> rtl/kmcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmcr_pkg
// Types, defaults and helpers for the keypad matrix change reporter.
// ----------------------------------------------------------------------------
package kmcr_pkg;

    localparam int PORT_COUNT_DEF       = 3;
    localparam int COLUMNS_PER_PORT_DEF = 4;
    localparam int ROWS_PER_COLUMN_DEF  = 8;

    localparam int WORD_W   = 32;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 4'd8;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 4'd12;

    typedef struct packed {
        logic [1:0]        port_index;
        logic [WORD_W-1:0] raw_port_word;
    } in_item_t;

    typedef struct packed {
        logic       event_valid;
        logic [2:0] key_row;
        logic [3:0] key_column;
        logic [6:0] scan_code;
        logic       key_down;
        logic       scan_done;
        logic       matrix_empty;
        logic       last_of_run;
    } out_item_t;

    // ceil(log2(cols)) for a 4-bit column count
    function automatic logic [2:0] code_shift(input logic [3:0] cols);
        logic [2:0] sh;
        sh = 3'd0;
        for (int s = 0; s < 4; s++)
        begin
            if ((5'd1 << s) < {1'b0, cols})
            begin
                sh = 3'(s + 1);
            end
        end
        return sh;
    endfunction

endpackage : kmcr_pkg
`default_nettype wire

>>> rtl/keypad_matrix_change_reporter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_change_reporter_core
// Masks an accepted port word, diffs it against the stored port state and walks
// the change word one bit per cycle (a changed bit waits while the output is
// full), emitting one event per changed key, or one empty result if none changed.
// The diff and the masked word are registered into the change and key-state shift
// registers on accept; each result is then loaded into the output register. A new
// port word is accepted only in idle, once the walk has passed the highest changed bit.
// Reset: no keys held, row_count 8, column_count 12; no clearing pass.
// ----------------------------------------------------------------------------
module keypad_matrix_change_reporter_core #(
    parameter int PORT_COUNT       = kmcr_pkg::PORT_COUNT_DEF,
    parameter int COLUMNS_PER_PORT = kmcr_pkg::COLUMNS_PER_PORT_DEF,
    parameter int ROWS_PER_COLUMN  = kmcr_pkg::ROWS_PER_COLUMN_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  kmcr_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output kmcr_pkg::out_item_t                  out_item,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [kmcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [kmcr_pkg::CFG_W-1:0]           cfg_data
);
    import kmcr_pkg::*;

    localparam int MAX_COLS = PORT_COUNT * COLUMNS_PER_PORT;
    localparam int PIDX_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SCAN = 1'b1;

    logic [0:0]        state_reg, state_next;
    logic [CFG_W-1:0]  row_count_reg, column_count_reg;
    logic [WORD_W-1:0] prev_state_reg [PORT_COUNT];
    logic              held_reg, held_next;

    logic [WORD_W-1:0] pend_reg, pend_next;
    logic [WORD_W-1:0] keyst_reg, keyst_next;
    logic [5:0]        base_reg, base_next;
    logic [2:0]        shift_reg, shift_next;
    logic              done_reg, done_next;
    logic              empty_reg, empty_next;
    logic              range_reg, range_next;
    logic [2:0]        row_reg, row_next;
    logic [1:0]        slice_reg, slice_next;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic [3:0]        eff_rows, eff_cols;
    logic [7:0]        row_bits;
    logic [5:0]        in_base;
    logic              in_range, in_done, held_acc, accept, out_free;
    logic [PIDX_W-1:0] in_pidx;
    logic [WORD_W-1:0] col_mask, cur_word, prev_rd;
    logic [3:0]        ev_col;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // clamp configuration to the wired range
    always_comb
    begin
        if (row_count_reg == 4'd0)
            eff_rows = 4'd1;
        else if (int'(row_count_reg) > ROWS_PER_COLUMN)
            eff_rows = 4'(ROWS_PER_COLUMN);
        else
            eff_rows = row_count_reg;

        if (column_count_reg == 4'd0)
            eff_cols = 4'd1;
        else if (int'(column_count_reg) > MAX_COLS)
            eff_cols = 4'(MAX_COLS);
        else
            eff_cols = column_count_reg;
    end

    assign row_bits = 8'((9'd1 << eff_rows) - 9'd1);
    assign in_base  = 6'(in_item.port_index) * 6'(COLUMNS_PER_PORT);
    assign in_range = (in_base < {2'b00, eff_cols})
                      && (int'(in_item.port_index) < PORT_COUNT);
    assign in_done  = (7'(in_base) + 7'(COLUMNS_PER_PORT)) >= {3'b000, eff_cols};
    assign in_pidx  = PIDX_W'(in_item.port_index);

    always_comb
    begin
        col_mask = '0;
        for (int s = 0; s < COLUMNS_PER_PORT; s++)
        begin
            if ((in_base + 6'(s)) < {2'b00, eff_cols})
            begin
                col_mask[s*ROWS_PER_COLUMN +: ROWS_PER_COLUMN] = row_bits[ROWS_PER_COLUMN-1:0];
            end
        end
    end

    assign cur_word = ~in_item.raw_port_word & col_mask;
    assign prev_rd  = prev_state_reg[in_pidx];
    assign held_acc = ((in_item.port_index == 2'd0) ? 1'b0 : held_reg) | (cur_word != '0);
    assign ev_col   = 4'(base_reg + 6'(slice_reg));

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        pend_next      = pend_reg;
        keyst_next     = keyst_reg;
        base_next      = base_reg;
        shift_next     = shift_reg;
        done_next      = done_reg;
        empty_next     = empty_reg;
        range_next     = range_reg;
        row_next       = row_reg;
        slice_next     = slice_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    range_next = in_range;
                    pend_next  = in_range ? (cur_word ^ prev_rd) : '0;
                    keyst_next = cur_word;
                    base_next  = in_base;
                    shift_next = code_shift(eff_cols);
                    done_next  = in_range && in_done;
                    empty_next = in_range && in_done && !held_acc;
                    row_next   = 3'd0;
                    slice_next = 2'd0;
                    if (in_range)
                        held_next = in_done ? 1'b0 : held_acc;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg == '0)
                begin
                    // no change or ignored port: one empty result
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = '0;
                        out_item_next.scan_done    = done_reg;
                        out_item_next.matrix_empty = empty_reg;
                        out_item_next.last_of_run  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!pend_reg[0] || out_free)
                begin
                    if (pend_reg[0])
                    begin
                        out_valid_next = 1'b1;
                        out_item_next.event_valid  = 1'b1;
                        out_item_next.key_row      = row_reg;
                        out_item_next.key_column   = ev_col;
                        out_item_next.scan_code    =
                            7'((8'(row_reg) << shift_reg) + 8'(ev_col));
                        out_item_next.key_down     = keyst_reg[0];
                        out_item_next.scan_done    = done_reg;
                        out_item_next.matrix_empty = empty_reg;
                        out_item_next.last_of_run  = (pend_reg[WORD_W-1:1] == '0);
                        if (pend_reg[WORD_W-1:1] == '0)
                            state_next = ST_IDLE;
                    end
                    pend_next  = pend_reg >> 1;
                    keyst_next = keyst_reg >> 1;
                    if (row_reg == 3'(ROWS_PER_COLUMN - 1))
                    begin
                        row_next   = 3'd0;
                        slice_next = slice_reg + 2'd1;
                    end
                    else
                    begin
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            row_count_reg    <= ROW_COUNT_RST;
            column_count_reg <= COLUMN_COUNT_RST;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                prev_state_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    row_count_reg <= cfg_data;
                else if (cfg_index == REG_COLUMN_COUNT)
                    column_count_reg <= cfg_data;
            end
            if (accept && in_range)
                prev_state_reg[in_pidx] <= cur_word;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        keyst_reg    <= keyst_next;
        base_reg     <= base_next;
        shift_reg    <= shift_next;
        done_reg     <= done_next;
        empty_reg    <= empty_next;
        range_reg    <= range_next;
        row_reg      <= row_next;
        slice_reg    <= slice_next;
        out_item_reg <= out_item_next;
    end

    // an accepted beat always starts a walk
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted beat did not start a scan");

    // a result is only produced by the walk
    a_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_SCAN))
        else $error("result loaded outside scan");

    // the final result of a run ends the walk
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_IDLE) |-> out_item_next.last_of_run)
        else $error("walk ended without last_of_run");

    // ignored ports never report a key change
    a_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !range_reg) |-> (pend_reg == '0))
        else $error("change pending for ignored port");

endmodule : keypad_matrix_change_reporter_core
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad matrix change reporter core. Port words
// go in with random burst pacing. Each accepted word runs through a local
// model of the mask, diff and bit walk. Every key report that comes out is
// compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module tb_top;
    import kmcr_pkg::*;

    localparam int PORTS        = PORT_COUNT_DEF;
    localparam int COLS_PP      = COLUMNS_PER_PORT_DEF;
    localparam int ROWS_PC      = ROWS_PER_COLUMN_DEF;
    localparam int MAX_COLS     = PORTS * COLS_PP;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int WORDS_PER_SETTING = 30;
    localparam int N_SETTINGS   = 10;
    localparam int N_DIRECTED   = 19;
    localparam int HOLD_AT      = N_DIRECTED + 12;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [1:0]  port;
        logic [31:0] word;
        logic        pinned;
        out_item_t   want;
    } vector_t;

    // no change on a port before the last one, or an ignored port
    localparam out_item_t QUIET_REPORT =
        '{1'b0, 3'd0, 4'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam out_item_t QUIET_SCAN_END =
        '{1'b0, 3'd0, 4'd0, 7'd0, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam out_item_t UNPINNED = '0;

    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{2'd0, 32'hFFFF_FFFF, 1'b1, QUIET_REPORT},
        '{2'd3, 32'h0000_0000, 1'b1, QUIET_REPORT},
        '{2'd2, 32'hFFFF_FFFF, 1'b1, QUIET_SCAN_END},
        '{2'd0, 32'h0000_0000, 1'b0, UNPINNED},
        '{2'd1, 32'hFFFF_FFFE, 1'b1, '{1'b1, 3'd0, 4'd4, 7'd4, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{2'd2, 32'h7FFF_FFFF, 1'b1, '{1'b1, 3'd7, 4'd11, 7'd123, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{2'd1, 32'hFFFF_FFFE, 1'b1, QUIET_REPORT},
        '{2'd0, 32'hFFFF_FFFF, 1'b0, UNPINNED},
        '{2'd1, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd0, 4'd4, 7'd4, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{2'd2, 32'hFFFF_FFFF, 1'b1, '{1'b1, 3'd7, 4'd11, 7'd123, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{2'd2, 32'h0000_0000, 1'b0, UNPINNED},
        '{2'd1, 32'h00FF_00FF, 1'b0, UNPINNED},
        '{2'd0, 32'hA5A5_A5A5, 1'b0, UNPINNED},
        '{2'd1, 32'h5A5A_5A5A, 1'b0, UNPINNED},
        '{2'd2, 32'h0F0F_0F0F, 1'b0, UNPINNED},
        '{2'd3, 32'hFFFF_FFFF, 1'b1, QUIET_REPORT},
        '{2'd0, 32'h0000_0000, 1'b0, UNPINNED},
        '{2'd1, 32'hFFFF_0000, 1'b0, UNPINNED},
        '{2'd2, 32'h0000_FFFF, 1'b0, UNPINNED}
    };

    // register settings per random phase; out-of-range values check clamping
    localparam logic [CFG_W-1:0] ROW_SET [N_SETTINGS] =
        '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7, 4'd8};
    localparam logic [CFG_W-1:0] COL_SET [N_SETTINGS] =
        '{4'd1, 4'd15, 4'd0, 4'd12, 4'd5, 4'd4, 4'd9, 4'd8, 4'd13, 4'd12};

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_item_t           in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // local copy of the block state
    logic [31:0]  port_state [PORTS];
    logic         any_held;
    logic [CFG_W-1:0] row_reg;
    logic [CFG_W-1:0] col_reg;
    out_item_t    key_reports [$];

    logic [31:0]  drive_word [4];
    int           burst_left;
    int           words_sent;
    int           live_words;
    int           reports_seen;
    int           fail_count;

    keypad_matrix_change_reporter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned wired_rows();
        if (row_reg == 0)
            return 1;
        if (row_reg > ROWS_PC)
            return ROWS_PC;
        return row_reg;
    endfunction

    function automatic int unsigned wired_cols();
        if (col_reg == 0)
            return 1;
        if (col_reg > MAX_COLS)
            return MAX_COLS;
        return col_reg;
    endfunction

    function automatic int unsigned live_ports();
        return (wired_cols() + COLS_PP - 1) / COLS_PP;
    endfunction

    // Mask and diff one port word, queue one report per changed key, or one empty report if none.
    function automatic void report_changes(input logic [1:0] port, input logic [31:0] raw);
        int unsigned rows;
        int unsigned cols;
        int unsigned shift;
        int unsigned remaining;
        int unsigned row;
        int unsigned col;
        logic [31:0] mask;
        logic [31:0] now_held;
        logic [31:0] diff;
        out_item_t   r;
        rows = wired_rows();
        cols = wired_cols();
        r    = '0;
        if (port >= live_ports())
        begin
            r.last_of_run = 1'b1;
            key_reports.push_back(r);
            return;
        end
        shift = 0;
        while ((1 << shift) < cols)
            shift++;
        mask = '0;
        for (int s = 0; s < COLS_PP; s++)
        begin
            if (port * COLS_PP + s < cols)
                mask |= ((32'd1 << rows) - 32'd1) << (s * ROWS_PC);
        end
        now_held = ~raw & mask;
        diff     = now_held ^ port_state[port];
        port_state[port] = now_held;
        if (port == 0)
            any_held = 1'b0;
        if (now_held != 0)
            any_held = 1'b1;
        r.scan_done    = (port == live_ports() - 1);
        r.matrix_empty = r.scan_done && !any_held;
        remaining = $countones(diff);
        for (int b = 0; b < 32; b++)
        begin
            if (diff[b])
            begin
                row = b % ROWS_PC;
                col = port * COLS_PP + b / ROWS_PC;
                remaining--;
                r.event_valid = 1'b1;
                r.key_row     = 3'(row);
                r.key_column  = 4'(col);
                r.scan_code   = 7'((row << shift) + col);
                r.key_down    = now_held[b];
                r.last_of_run = (remaining == 0);
                key_reports.push_back(r);
            end
        end
        if (diff == 0)
        begin
            r.last_of_run = 1'b1;
            key_reports.push_back(r);
        end
        if (r.scan_done)
            any_held = 1'b0;
    endfunction

    // Mostly single key flips, most inside the wired rows, now and then a full change or a random word.
    function automatic logic [31:0] next_word(input int p);
        case ($urandom_range(0, 9))
            0: drive_word[p] = '1;
            1: drive_word[p] = '0;
            2: drive_word[p] = $urandom;
            3: drive_word[p] ^= 32'd1 << $urandom_range(0, 31);
            default: drive_word[p] ^= 32'd1 << ($urandom_range(0, COLS_PP - 1) * ROWS_PC
                                                + $urandom_range(0, wired_rows() - 1));
        endcase
        return drive_word[p];
    endfunction

    task automatic send_word(input logic [1:0] port, input logic [31:0] word,
                             input logic pinned, input out_item_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= '{port_index: port, raw_port_word: word};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (port < live_ports())
            live_words++;
        report_changes(port, word);
        // pinned rows produce exactly one report
        if (pinned)
            key_reports[key_reports.size() - 1] = want;
        words_sent++;
        burst_left--;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (key_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_ROW_COUNT)
            row_reg = val;
        else if (idx == REG_COLUMN_COUNT)
            col_reg = val;
    endtask

    task automatic flag(input string field, input logic [6:0] exp_v, input logic [6:0] act_v);
        $display("%0t ns  %s: expected %0d, got %0d", $time, field, exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : report_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (key_reports.size() == 0)
            begin
                $display("%0t ns  report with none pending: expected nothing, got %h",
                         $time, out_item);
                fail_count++;
            end
            else
            begin
                want = key_reports.pop_front();
                if (out_item.event_valid !== want.event_valid)
                    flag("event_valid", want.event_valid, out_item.event_valid);
                if (out_item.key_row !== want.key_row)
                    flag("key_row", want.key_row, out_item.key_row);
                if (out_item.key_column !== want.key_column)
                    flag("key_column", want.key_column, out_item.key_column);
                if (out_item.scan_code !== want.scan_code)
                    flag("scan_code", want.scan_code, out_item.scan_code);
                if (out_item.key_down !== want.key_down)
                    flag("key_down", want.key_down, out_item.key_down);
                if (out_item.scan_done !== want.scan_done)
                    flag("scan_done", want.scan_done, out_item.scan_done);
                if (out_item.matrix_empty !== want.matrix_empty)
                    flag("matrix_empty", want.matrix_empty, out_item.matrix_empty);
                if (out_item.last_of_run !== want.last_of_run)
                    flag("last_of_run", want.last_of_run, out_item.last_of_run);
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off mid-run
    initial
    begin : drain_side
        int  mode;
        int  span;
        bit  held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (!held_off && words_sent >= HOLD_AT)
                begin
                    held_off = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (k % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int target;
        int pick;
        int lo;
        int hi;
        for (int i = 0; i < PORTS; i++)
            port_state[i] = '0;
        for (int i = 0; i < 4; i++)
            drive_word[i] = '1;
        any_held     = 1'b0;
        row_reg      = ROW_COUNT_RST;
        col_reg      = COLUMN_COUNT_RST;
        burst_left   = 0;
        words_sent   = 0;
        live_words   = 0;
        reports_seen = 0;
        fail_count   = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].port, DIRECTED[i].word, DIRECTED[i].pinned,
                      DIRECTED[i].want);

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            settle();
            write_reg(REG_ROW_COUNT, ROW_SET[s]);
            write_reg(REG_COLUMN_COUNT, COL_SET[s]);
            if (s == 4)
                write_reg(REG_UNMAPPED, 4'($urandom_range(0, 15)));
            @(negedge clk);
            cfg_valid <= 1'b0;
            target = live_words + WORDS_PER_SETTING;
            while (live_words < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    for (int p = 0; p < live_ports(); p++)
                        send_word(2'(p), next_word(p), 1'b0, UNPINNED);
                end
                else if (pick == 8)
                    send_word(2'($urandom_range(0, 3)), $urandom, 1'b0, UNPINNED);
                else
                begin
                    // scan started late, cut short or run past the last port
                    lo = $urandom_range(0, PORTS - 1);
                    hi = $urandom_range(lo, PORTS);
                    for (int p = lo; p <= hi; p++)
                        send_word(2'(p), next_word(p), 1'b0, UNPINNED);
                end
            end
        end

        settle();
        $display("Run covered %0d port words (%0d directed) over %0d register settings;",
                 words_sent, N_DIRECTED, N_SETTINGS + 1);
        $display("%0d key reports checked, with ignored ports, broken scans and a %0d-cycle hold-off.",
                 reports_seen, HOLD_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> keypad_matrix_change_reporter_core.f
rtl/kmcr_pkg.sv
rtl/keypad_matrix_change_reporter_core.sv
tb/tb_top.sv
